FILE: hdl/gpa_pkg.sv
// Shared types and constants for the pairwise gravity acceleration block.
`timescale 1ns / 1ps
package gpa_pkg;

	localparam int FIELD_W = 32;
	localparam int ACCEL_W = 48;

	localparam logic [FIELD_W-1:0] GRAVITY_RESET = 32'h0100_0000;

	// Word index of the register, taken from paddr[2]
	typedef enum logic [0:0] {
		REG_GRAVITY = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] first_pos_x;
		logic signed [FIELD_W-1:0] first_pos_y;
		logic signed [FIELD_W-1:0] first_pos_z;
		logic        [FIELD_W-1:0] first_mass;
		logic signed [FIELD_W-1:0] second_pos_x;
		logic signed [FIELD_W-1:0] second_pos_y;
		logic signed [FIELD_W-1:0] second_pos_z;
		logic        [FIELD_W-1:0] second_mass;
	} pair_t;

	typedef struct packed {
		logic signed [ACCEL_W-1:0] first_accel_x;
		logic signed [ACCEL_W-1:0] first_accel_y;
		logic signed [ACCEL_W-1:0] first_accel_z;
		logic signed [ACCEL_W-1:0] second_accel_x;
		logic signed [ACCEL_W-1:0] second_accel_y;
		logic signed [ACCEL_W-1:0] second_accel_z;
		logic                      coincident;
	} accel_t;

endpackage

FILE: hdl/gpa_mul.sv
// Three-stage unsigned multiplier built from 32x32 partial products.
`timescale 1ns / 1ps
module gpa_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic [AW+BW-1:0] p
);

	localparam int CW = 32;
	localparam int NA = (AW + CW - 1) / CW;
	localparam int NB = (BW + CW - 1) / CW;
	localparam int RWD = NA * CW + CW;
	localparam int PWD = NA * CW + NB * CW;

	logic [NA*CW-1:0] a_ext;
	logic [NB*CW-1:0] b_ext;
	logic [2*CW-1:0]  pp_s1 [NA][NB];
	logic [RWD-1:0]   row_d [NB];
	logic [RWD-1:0]   row_s2 [NB];
	logic [PWD-1:0]   sum_d;
	logic [PWD-1:0]   sum_s3;

	assign a_ext = (NA*CW)'(a);
	assign b_ext = (NB*CW)'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= (2*CW)'(a_ext[i*CW +: CW]) * (2*CW)'(b_ext[j*CW +: CW]);
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < NB; j++) begin
			row_d[j] = '0;
			for (int i = 0; i < NA; i++) begin
				row_d[j] = row_d[j] + (RWD'(pp_s1[i][j]) << (CW * i));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s2 <= row_d;
		end
	end

	always_comb begin
		sum_d = '0;
		for (int j = 0; j < NB; j++) begin
			sum_d = sum_d + (PWD'(row_s2[j]) << (CW * j));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= sum_d;
		end
	end

	assign p = sum_s3[AW+BW-1:0];

endmodule

FILE: hdl/gravity_pair_acceleration.sv
// Pipelined pairwise gravitational acceleration with saturated Q24.24 results.
// Accepts one body pair per clock while not stalled and returns one beat per pair,
// in order: a registered stage forms the separation, pipelined multipliers form
// squares, mass and G products and S*r, a square root takes one pipeline stage per
// root bit (POSITION_WIDTH + 2), and each of the six quotients takes 47 restoring
// stages plus a saturation check. A stall on the result side holds the whole
// pipeline; the gravity constant is written over APB at byte address 0 and reads
// back there.
`timescale 1ns / 1ps
module gravity_pair_acceleration
	import gpa_pkg::*;
#(
	parameter int POSITION_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pair_valid,
	output logic        pair_stall,
	input  pair_t       pair,
	output logic        accel_valid,
	input  logic        accel_stall,
	output accel_t      accel
);

	localparam int PW  = POSITION_WIDTH;
	localparam int DW  = PW + 1;            // separation magnitude
	localparam int RW  = DW + 1;            // root
	localparam int SW  = 2 * RW;            // sum of squares
	localparam int DDW = SW + RW;           // S * r
	localparam int MW  = DW + FIELD_W;      // |d| * m
	localparam int NW  = MW + FIELD_W;      // |d| * m * G
	localparam int QB  = ACCEL_W - 1;       // quotient bits below saturation
	localparam int WW  = DDW + ACCEL_W;
	localparam int LAT = 10 + RW + QB;
	localparam int NEG_DLY = RW + 7;
	localparam int NUM_DLY = RW + 1;

	// config register
	logic [FIELD_W-1:0] gravity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= GRAVITY_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_GRAVITY) begin
			gravity_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_GRAVITY) ? gravity_q : '0;

	// flow control: whole pipeline moves together
	logic           adv;
	logic [LAT-1:0] vld_q;

	assign adv         = !(accel_valid && accel_stall);
	assign pair_stall  = !adv;
	assign accel_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], pair_valid};
		end
	end

	// stage 1: separation magnitude and sign
	logic [PW-1:0] pa [3];
	logic [PW-1:0] pb [3];
	logic [DW-1:0] diff [3];
	logic [DW-1:0] mag_s1 [3];
	logic [2:0]    neg_s1;
	logic [FIELD_W-1:0] m1_s1, m2_s1;

	generate
		if (PW <= FIELD_W) begin : g_narrow
			assign pa[0] = pair.first_pos_x[PW-1:0];
			assign pa[1] = pair.first_pos_y[PW-1:0];
			assign pa[2] = pair.first_pos_z[PW-1:0];
			assign pb[0] = pair.second_pos_x[PW-1:0];
			assign pb[1] = pair.second_pos_y[PW-1:0];
			assign pb[2] = pair.second_pos_z[PW-1:0];
		end else begin : g_wide
			assign pa[0] = {{(PW-FIELD_W){pair.first_pos_x[FIELD_W-1]}}, pair.first_pos_x};
			assign pa[1] = {{(PW-FIELD_W){pair.first_pos_y[FIELD_W-1]}}, pair.first_pos_y};
			assign pa[2] = {{(PW-FIELD_W){pair.first_pos_z[FIELD_W-1]}}, pair.first_pos_z};
			assign pb[0] = {{(PW-FIELD_W){pair.second_pos_x[FIELD_W-1]}}, pair.second_pos_x};
			assign pb[1] = {{(PW-FIELD_W){pair.second_pos_y[FIELD_W-1]}}, pair.second_pos_y};
			assign pb[2] = {{(PW-FIELD_W){pair.second_pos_z[FIELD_W-1]}}, pair.second_pos_z};
		end
	endgenerate

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = {pa[k][PW-1], pa[k]} - {pb[k][PW-1], pb[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				neg_s1[k] <= diff[k][DW-1];
				mag_s1[k] <= diff[k][DW-1] ? (~diff[k] + 1'b1) : diff[k];
			end
			m1_s1 <= pair.first_mass;
			m2_s1 <= pair.second_mass;
		end
	end

	// squares, mass products and G products
	logic [2*DW-1:0] sqr [3];
	logic [MW-1:0]   dm [6];
	logic [NW-1:0]   num [6];

	for (genvar k = 0; k < 3; k++) begin : g_sq
		gpa_mul #(.AW(DW), .BW(DW)) u_sq (
			.clk (clk),
			.en  (adv),
			.a   (mag_s1[k]),
			.b   (mag_s1[k]),
			.p   (sqr[k])
		);
	end

	// lanes 0..2 act on the first body (scaled by m2), 3..5 on the second
	for (genvar l = 0; l < 6; l++) begin : g_lane
		gpa_mul #(.AW(DW), .BW(FIELD_W)) u_dm (
			.clk (clk),
			.en  (adv),
			.a   (mag_s1[l % 3]),
			.b   ((l < 3) ? m2_s1 : m1_s1),
			.p   (dm[l])
		);
		gpa_mul #(.AW(MW), .BW(FIELD_W)) u_num (
			.clk (clk),
			.en  (adv),
			.a   (dm[l]),
			.b   (gravity_q),
			.p   (num[l])
		);
	end

	// sign delay up to the divider entry
	logic [2:0] neg_dly_q [NEG_DLY];

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_dly_q[0] <= neg_s1;
			for (int i = 1; i < NEG_DLY; i++) begin
				neg_dly_q[i] <= neg_dly_q[i-1];
			end
		end
	end

	// numerator delay across the square root and S*r
	logic [NW-1:0] num_dly_q [NUM_DLY][6];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 6; l++) begin
				num_dly_q[0][l] <= num[l];
				for (int i = 1; i < NUM_DLY; i++) begin
					num_dly_q[i][l] <= num_dly_q[i-1][l];
				end
			end
		end
	end

	// square root, one root bit per stage; index 0 holds S
	logic [SW-1:0]   sq_src_q  [RW+1];
	logic [RW+1:0]   sq_rem_q  [RW+1];
	logic [RW-1:0]   sq_root_q [RW+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_src_q[0]  <= SW'(sqr[0]) + SW'(sqr[1]) + SW'(sqr[2]);
			sq_rem_q[0]  <= '0;
			sq_root_q[0] <= '0;
		end
	end

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		localparam int BI = RW - 1 - k;
		logic [RW+1:0] rem_n;
		logic [RW+1:0] trial;

		assign rem_n = {sq_rem_q[k][RW-1:0], sq_src_q[k][2*BI+1 -: 2]};
		assign trial = {sq_root_q[k], 2'b01};

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_src_q[k+1] <= sq_src_q[k];
				if (rem_n >= trial) begin
					sq_rem_q[k+1]  <= rem_n - trial;
					sq_root_q[k+1] <= {sq_root_q[k][RW-2:0], 1'b1};
				end else begin
					sq_rem_q[k+1]  <= rem_n;
					sq_root_q[k+1] <= {sq_root_q[k][RW-2:0], 1'b0};
				end
			end
		end
	end

	// denominator S * r
	logic [DDW-1:0] den;
	logic [SW-1:0]  s_dly_q [3];

	gpa_mul #(.AW(SW), .BW(RW)) u_den (
		.clk (clk),
		.en  (adv),
		.a   (sq_src_q[RW]),
		.b   (sq_root_q[RW]),
		.p   (den)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			s_dly_q[0] <= sq_src_q[RW];
			s_dly_q[1] <= s_dly_q[0];
			s_dly_q[2] <= s_dly_q[1];
		end
	end

	// restoring division, one quotient bit per stage; index 0 is the saturation check
	logic [WW-1:0]  dv_rem_q  [QB+1][6];
	logic [QB-1:0]  dv_quo_q  [QB+1][6];
	logic [5:0]     dv_sat_q  [QB+1];
	logic [DDW-1:0] dv_den_q  [QB+1];
	logic [2:0]     dv_neg_q  [QB+1];
	logic           dv_coin_q [QB+1];
	logic [WW-1:0]  sat_lim;

	assign sat_lim = WW'(den) << QB;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 6; l++) begin
				dv_rem_q[0][l] <= WW'(num_dly_q[NUM_DLY-1][l]);
				dv_quo_q[0][l] <= '0;
				dv_sat_q[0][l] <= WW'(num_dly_q[NUM_DLY-1][l]) >= sat_lim;
			end
			dv_den_q[0]  <= den;
			dv_neg_q[0]  <= neg_dly_q[NEG_DLY-1];
			dv_coin_q[0] <= (s_dly_q[2] == '0);
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int BI = QB - 1 - j;
		logic [WW-1:0] trial;

		assign trial = WW'(dv_den_q[j]) << BI;

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 6; l++) begin
					if (dv_rem_q[j][l] >= trial) begin
						dv_rem_q[j+1][l] <= dv_rem_q[j][l] - trial;
						dv_quo_q[j+1][l] <= dv_quo_q[j][l] | (QB'(1) << BI);
					end else begin
						dv_rem_q[j+1][l] <= dv_rem_q[j][l];
						dv_quo_q[j+1][l] <= dv_quo_q[j][l];
					end
				end
				dv_sat_q[j+1]  <= dv_sat_q[j];
				dv_den_q[j+1]  <= dv_den_q[j];
				dv_neg_q[j+1]  <= dv_neg_q[j];
				dv_coin_q[j+1] <= dv_coin_q[j];
			end
		end
	end

	// sign, clamp and output register
	logic [ACCEL_W-1:0] qv  [6];
	logic [ACCEL_W-1:0] val [6];
	logic               lane_neg;
	accel_t             accel_d;
	accel_t             accel_q;

	always_comb begin
		lane_neg = 1'b0;
		for (int l = 0; l < 6; l++) begin
			// first body pulls toward the second, so its sign is opposite to d
			lane_neg = (l < 3) ? !dv_neg_q[QB][l % 3] : dv_neg_q[QB][l % 3];
			qv[l] = dv_sat_q[QB][l] ? (ACCEL_W'(1) << QB) : {1'b0, dv_quo_q[QB][l]};
			if (dv_coin_q[QB]) begin
				val[l] = '0;
			end else if (lane_neg) begin
				val[l] = ~qv[l] + 1'b1;
			end else if (qv[l][ACCEL_W-1]) begin
				val[l] = {1'b0, {(ACCEL_W-1){1'b1}}};
			end else begin
				val[l] = qv[l];
			end
		end
		accel_d.first_accel_x  = val[0];
		accel_d.first_accel_y  = val[1];
		accel_d.first_accel_z  = val[2];
		accel_d.second_accel_x = val[3];
		accel_d.second_accel_y = val[4];
		accel_d.second_accel_z = val[5];
		accel_d.coincident     = dv_coin_q[QB];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			accel_q <= accel_d;
		end
	end

	assign accel = accel_q;

endmodule
